>>> rtl/bpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the barometric pressure compensation unit.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned RegIdxW = 3;
  localparam int unsigned CfgW    = 32;

  typedef enum logic [RegIdxW-1:0] {
    REG_OSS  = 3'd0,
    REG_AC12 = 3'd1,
    REG_AC34 = 3'd2,
    REG_AC56 = 3'd3,
    REG_B12  = 3'd4,
    REG_MCMD = 3'd5
  } bpc_reg_t;

  localparam logic signed [29:0] TempOffset = 30'sd4000;
  localparam logic [31:0]        B4Bias     = 32'd32768;
  localparam logic [31:0]        B7Scale    = 32'd50000;
  localparam logic [11:0]        PolyA      = 12'd3038;
  localparam logic signed [14:0] PolyB      = -15'sd7357;
  localparam logic signed [45:0] PolyC      = 46'sd3791;
  localparam logic [19:0]        PressMax   = 20'hFFFFF;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure;
  } bpc_req_t;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic [19:0]        pressure_pa;
    logic               status;
  } bpc_res_t;

  typedef struct packed {
    logic [1:0]         oss;
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic [15:0]        ac4;
    logic [15:0]        ac5;
    logic [15:0]        ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
  } bpc_cal_t;

  typedef struct packed {
    logic signed [29:0] b6;
    logic signed [15:0] t;
    logic               dz;
    logic [23:0]        raw_pressure;
  } bpc_tmp_t;

  typedef struct packed {
    logic [31:0]        b7;
    logic [16:0]        b4;
    logic signed [15:0] t;
    logic               dz;
  } bpc_coef_t;

endpackage
`default_nettype wire

>>> rtl/bpc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_div
// Pipelined restoring unsigned divider, one quotient bit per stage, with a
// sideband word that travels alongside.
// ----------------------------------------------------------------------------
module bpc_div #(
  parameter int NW = 32,
  parameter int DW = 17,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] quotient,
  output logic [SW-1:0] out_side
);

  logic          vld [NW+1];
  logic [NW-1:0] dvd [NW+1];
  logic [DW-1:0] dsr [NW+1];
  logic [DW-1:0] rem [NW+1];
  logic [SW-1:0] sd  [NW+1];

  assign vld[0] = in_valid;
  assign dvd[0] = dividend;
  assign dsr[0] = divisor;
  assign rem[0] = '0;
  assign sd[0]  = in_side;

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW:0] tr;
    logic [DW:0] diff;
    logic        ge;

    always_comb begin
      tr   = {rem[i], dvd[i][NW-1]};
      diff = tr - {1'b0, dsr[i]};
      ge   = (tr >= {1'b0, dsr[i]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      dvd[i+1] <= {dvd[i][NW-2:0], ge};
      rem[i+1] <= ge ? diff[DW-1:0] : tr[DW-1:0];
      dsr[i+1] <= dsr[i];
      sd[i+1]  <= sd[i];
    end
  end

  assign out_valid = vld[NW];
  assign quotient  = dvd[NW];
  assign out_side  = sd[NW];

endmodule
`default_nettype wire

>>> rtl/bpc_temp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_temp
// Temperature path: X1, divisor, signed divide for X2, B5, saturated
// temperature and B6.
// ----------------------------------------------------------------------------
module bpc_temp (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  bpc_pkg::bpc_req_t   req,
  input  bpc_pkg::bpc_cal_t   cal,
  output logic                out_valid,
  output bpc_pkg::bpc_tmp_t   tmp
);
  import bpc_pkg::*;

  typedef struct packed {
    logic signed [19:0] x1;
    logic               neg;
    logic               dz;
    logic [23:0]        raw_pressure;
  } side_t;

  logic               s1_valid;
  logic signed [17:0] s1_d;
  bpc_req_t           s1_req;
  logic               s2_valid;
  logic signed [34:0] s2_prod;
  bpc_req_t           s2_req;
  logic               s3_valid;
  logic signed [19:0] s3_x1;
  logic signed [19:0] s3_den;
  bpc_req_t           s3_req;

  logic [15:0]        mc_abs;
  logic [19:0]        den_abs;
  side_t              div_side;
  logic [$bits(side_t)-1:0] div_side_out;
  side_t              dq_side;
  logic               dq_valid;
  logic [26:0]        dq;

  logic signed [27:0] x2;
  logic signed [29:0] b5_next;
  logic               s4_valid;
  logic signed [29:0] s4_b5;
  logic               s4_dz;
  logic [23:0]        s4_rp;

  logic signed [29:0] b5_rnd;
  logic signed [25:0] t_wide;
  logic signed [15:0] t_sat;
  logic               s5_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
    s1_d    <= $signed({2'b00, req.raw_temperature}) - $signed({2'b00, cal.ac6});
    s1_req  <= req;
    s2_prod <= s1_d * $signed({1'b0, cal.ac5});
    s2_req  <= s1_req;
    s3_x1   <= $signed(s2_prod[34:15]);
    s3_den  <= $signed(s2_prod[34:15]) + {{4{cal.md[15]}}, cal.md};
    s3_req  <= s2_req;
  end

  always_comb begin
    mc_abs                = cal.mc[15] ? 16'(-cal.mc) : cal.mc;
    den_abs               = s3_den[19] ? 20'(-s3_den) : s3_den;
    div_side.x1           = s3_x1;
    div_side.neg          = cal.mc[15] ^ s3_den[19];
    div_side.dz           = (s3_den == '0);
    div_side.raw_pressure = s3_req.raw_pressure;
  end

  bpc_div #(
    .NW(27),
    .DW(20),
    .SW($bits(side_t))
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s3_valid),
    .dividend ({mc_abs, 11'd0}),
    .divisor  (den_abs),
    .in_side  (div_side),
    .out_valid(dq_valid),
    .quotient (dq),
    .out_side (div_side_out)
  );

  always_comb begin
    dq_side = side_t'(div_side_out);
    x2      = dq_side.neg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});
    b5_next = {{10{dq_side.x1[19]}}, dq_side.x1} + {{2{x2[27]}}, x2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      s4_valid <= dq_valid;
      s5_valid <= s4_valid;
    end
    s4_b5 <= b5_next;
    s4_dz <= dq_side.dz;
    s4_rp <= dq_side.raw_pressure;
    tmp.b6           <= s4_b5 - TempOffset;
    tmp.t            <= t_sat;
    tmp.dz           <= s4_dz;
    tmp.raw_pressure <= s4_rp;
  end

  always_comb begin
    b5_rnd = s4_b5 + 30'sd8;
    t_wide = $signed(b5_rnd[29:4]);
    if (t_wide > 26'sd32767) begin
      t_sat = 16'sh7FFF;
    end else if (t_wide < -26'sd32768) begin
      t_sat = 16'sh8000;
    end else begin
      t_sat = t_wide[15:0];
    end
  end

  assign out_valid = s5_valid;

endmodule
`default_nettype wire

>>> rtl/bpc_coef.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_coef
// Pressure coefficients: B3, B4 and B7 from B6 and the calibration set.
// ----------------------------------------------------------------------------
module bpc_coef (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  bpc_pkg::bpc_tmp_t   tmp,
  input  bpc_pkg::bpc_cal_t   cal,
  output logic                out_valid,
  output bpc_pkg::bpc_coef_t  coef
);
  import bpc_pkg::*;

  logic [6:0]         vld;
  logic signed [15:0] t_d   [6];
  logic               dz_d  [6];
  logic [23:0]        rp_d  [5];

  logic signed [59:0] c1_sq;
  logic signed [45:0] c1_a2;
  logic signed [45:0] c1_a3;
  logic signed [63:0] c2_m2;
  logic signed [63:0] c2_m1;
  logic signed [34:0] c2_x2a;
  logic signed [32:0] c2_x1b;
  logic signed [63:0] c3_x3;
  logic signed [61:0] c3_x3b;
  logic signed [63:0] x3b_sum;
  logic signed [63:0] c4_v;
  logic [31:0]        c4_u;
  logic signed [63:0] w;
  logic signed [63:0] w_adj;
  logic [31:0]        c5_b3;
  logic [31:0]        c5_b4p;
  logic [31:0]        up;
  logic [31:0]        c6_dp;
  logic [16:0]        c6_b4;

  always_comb begin
    x3b_sum = $signed(c2_m1[63:16]) + c2_x1b + 64'sd2;
    w       = c4_v + 64'sd2;
    w_adj   = w[63] ? (w + 64'sd3) : w;
    up      = 32'(tmp_rp_shift(rp_d[4], cal.oss));
  end

  function automatic logic [23:0] tmp_rp_shift(input logic [23:0] rp, input logic [1:0] oss);
    logic [3:0] sh;
    sh = 4'd8 - {2'b00, oss};
    return rp >> sh;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[5:0], in_valid};
    end
    t_d[0]  <= tmp.t;
    dz_d[0] <= tmp.dz;
    rp_d[0] <= tmp.raw_pressure;
    for (int i = 1; i < 6; i++) begin
      t_d[i]  <= t_d[i-1];
      dz_d[i] <= dz_d[i-1];
    end
    for (int i = 1; i < 5; i++) begin
      rp_d[i] <= rp_d[i-1];
    end

    c1_sq  <= tmp.b6 * tmp.b6;
    c1_a2  <= cal.ac2 * tmp.b6;
    c1_a3  <= cal.ac3 * tmp.b6;

    c2_m2  <= cal.b2 * $signed(c1_sq[59:12]);
    c2_m1  <= cal.b1 * $signed(c1_sq[59:12]);
    c2_x2a <= $signed(c1_a2[45:11]);
    c2_x1b <= $signed(c1_a3[45:13]);

    c3_x3  <= $signed(c2_m2[63:11]) + c2_x2a;
    c3_x3b <= x3b_sum[63:2];

    c4_v   <= (($signed(cal.ac1) * 64'sd4) + c3_x3) <<< cal.oss;
    c4_u   <= c3_x3b[31:0] + B4Bias;

    c5_b3  <= w_adj[33:2];
    c5_b4p <= c4_u * {16'd0, cal.ac4};

    c6_b4  <= c5_b4p[31:15];
    c6_dp  <= up - c5_b3;

    coef.b4 <= c6_b4;
    coef.b7 <= c6_dp * (B7Scale >> cal.oss);
    coef.t  <= t_d[5];
    coef.dz <= dz_d[5];
  end

  assign out_valid = vld[6];

endmodule
`default_nettype wire

>>> rtl/bpc_press.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_press
// Pressure quotient B7/B4, second-order correction, clamp and result
// register.
// ----------------------------------------------------------------------------
module bpc_press (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  bpc_pkg::bpc_coef_t  coef,
  output logic                out_valid,
  output bpc_pkg::bpc_res_t   res
);
  import bpc_pkg::*;

  typedef struct packed {
    logic               big;
    logic signed [15:0] t;
    logic               zf;
  } side_t;

  side_t              div_side;
  logic [$bits(side_t)-1:0] div_side_out;
  side_t              dq_side;
  logic               dq_valid;
  logic [31:0]        dq;
  logic [31:0]        dividend;
  logic [31:0]        pu;

  logic [3:0]         vld;
  logic signed [15:0] t_d  [3];
  logic               zf_d [3];

  logic [47:0]        p1_sq;
  logic signed [47:0] p1_m;
  logic [31:0]        p1_p;
  logic [59:0]        p2_x1p;
  logic signed [31:0] p2_x2;
  logic [31:0]        p2_p;
  logic signed [45:0] sum;
  logic signed [45:0] p3_pf;
  logic [19:0]        p_clamp;

  always_comb begin
    div_side.big = coef.b7[31];
    div_side.t   = coef.t;
    div_side.zf  = coef.dz | (coef.b4 == '0);
    dividend     = coef.b7[31] ? coef.b7 : {coef.b7[30:0], 1'b0};
  end

  bpc_div #(
    .NW(32),
    .DW(17),
    .SW($bits(side_t))
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .dividend (dividend),
    .divisor  (coef.b4),
    .in_side  (div_side),
    .out_valid(dq_valid),
    .quotient (dq),
    .out_side (div_side_out)
  );

  always_comb begin
    dq_side = side_t'(div_side_out);
    pu      = dq_side.big ? {dq[30:0], 1'b0} : dq;
    sum     = $signed({2'b00, p2_x1p[59:16]}) + p2_x2 + PolyC;
    if (p3_pf < 0) begin
      p_clamp = '0;
    end else if (p3_pf > $signed({26'd0, PressMax})) begin
      p_clamp = PressMax;
    end else begin
      p_clamp = p3_pf[19:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], dq_valid};
    end
    t_d[0]  <= dq_side.t;
    zf_d[0] <= dq_side.zf;
    for (int i = 1; i < 3; i++) begin
      t_d[i]  <= t_d[i-1];
      zf_d[i] <= zf_d[i-1];
    end

    p1_sq  <= pu[31:8] * pu[31:8];
    p1_m   <= PolyB * $signed({1'b0, pu});
    p1_p   <= pu;

    p2_x1p <= p1_sq * PolyA;
    p2_x2  <= $signed(p1_m[47:16]);
    p2_p   <= p1_p;

    p3_pf  <= $signed({14'd0, p2_p}) + {{4{sum[45]}}, sum[45:4]};

    if (zf_d[2]) begin
      res.temperature_tenths <= '0;
      res.pressure_pa        <= '0;
      res.status             <= 1'b1;
    end else begin
      res.temperature_tenths <= t_d[2];
      res.pressure_pa        <= p_clamp;
      res.status             <= 1'b0;
    end
  end

  assign out_valid = vld[3];

endmodule
`default_nettype wire

>>> rtl/barometric_pressure_compensation_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_unit
// Integer temperature and pressure compensation from raw sensor words.
// ----------------------------------------------------------------------------
// Takes one request per clock (busy is never raised) and returns each result,
// strobed by done for one cycle; the receiver cannot stall. The pipeline is
// built around two restoring dividers, one quotient bit per stage: 27 stages
// for the temperature divide and 32 for the pressure divide, plus the
// multiply and correction stages around them.
// A zero divisor gives status 1 with both values zero.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  bpc_pkg::bpc_req_t             request,
  output logic                          done,
  output bpc_pkg::bpc_res_t             result,
  input  logic                          cfg_we,
  input  logic [bpc_pkg::RegIdxW-1:0]   cfg_index,
  input  logic [bpc_pkg::CfgW-1:0]      cfg_data
);
  import bpc_pkg::*;

  logic [1:0]  oversampling;
  logic [31:0] cal_ac1_ac2;
  logic [31:0] cal_ac3_ac4;
  logic [31:0] cal_ac5_ac6;
  logic [31:0] cal_b1_b2;
  logic [31:0] cal_mc_md;

  bpc_cal_t    cal;
  bpc_tmp_t    tmp;
  bpc_coef_t   coef;
  logic        tmp_valid;
  logic        coef_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      oversampling <= '0;
      cal_ac1_ac2  <= '0;
      cal_ac3_ac4  <= '0;
      cal_ac5_ac6  <= '0;
      cal_b1_b2    <= '0;
      cal_mc_md    <= '0;
    end else if (cfg_we) begin
      case (bpc_reg_t'(cfg_index))
        REG_OSS:  oversampling <= cfg_data[1:0];
        REG_AC12: cal_ac1_ac2  <= cfg_data;
        REG_AC34: cal_ac3_ac4  <= cfg_data;
        REG_AC56: cal_ac5_ac6  <= cfg_data;
        REG_B12:  cal_b1_b2    <= cfg_data;
        REG_MCMD: cal_mc_md    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.oss = oversampling;
    cal.ac1 = cal_ac1_ac2[31:16];
    cal.ac2 = cal_ac1_ac2[15:0];
    cal.ac3 = cal_ac3_ac4[31:16];
    cal.ac4 = cal_ac3_ac4[15:0];
    cal.ac5 = cal_ac5_ac6[31:16];
    cal.ac6 = cal_ac5_ac6[15:0];
    cal.b1  = cal_b1_b2[31:16];
    cal.b2  = cal_b1_b2[15:0];
    cal.mc  = cal_mc_md[31:16];
    cal.md  = cal_mc_md[15:0];
  end

  assign busy = 1'b0;

  bpc_temp u_temp (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start & ~busy),
    .req      (request),
    .cal      (cal),
    .out_valid(tmp_valid),
    .tmp      (tmp)
  );

  bpc_coef u_coef (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tmp_valid),
    .tmp      (tmp),
    .cal      (cal),
    .out_valid(coef_valid),
    .coef     (coef)
  );

  bpc_press u_press (
    .clk      (clk),
    .rst      (rst),
    .in_valid (coef_valid),
    .coef     (coef),
    .out_valid(done),
    .res      (result)
  );

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status) |->
      (result.temperature_tenths == '0 && result.pressure_pa == '0))
    else $error("status set with nonzero outputs");

  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("done raised right after reset");

  a_no_busy: assert property (@(posedge clk) disable iff (rst)
    (start && $past(done)) |-> !busy)
    else $error("request refused while results drain");

endmodule
`default_nettype wire
